// ===== src/mi26_pkg.sv =====
// ----------------------------------------------------------------------------
// mi26_pkg
// Shared types and constants for the 2x2 matrix inverse modulo 26 block.
// ----------------------------------------------------------------------------
package mi26_pkg;

	// Modulus and field widths
	localparam int MODULUS = 26;
	localparam int FIELD_W = 5;
	// residue width (0..MODULUS-1) and width that also holds MODULUS itself
	localparam int RES_W = $clog2(MODULUS);
	localparam int DW = $clog2(MODULUS + 1);
	// product width as split into high and low halves for the divider
	localparam int PW = 2 * DW;
	// signed Bezout coefficient width, holds -MODULUS..MODULUS
	localparam int TW = DW + 2;
	// divider step counter width
	localparam int CW = $clog2(DW + 1);

	localparam logic signed [TW-1:0] MOD_T = TW'(MODULUS);

	// Reduce a raw 5-bit entry to a residue
	typedef logic [RES_W-1:0] red_tbl_t [0:(1 << FIELD_W) - 1];

	function automatic red_tbl_t build_red_tbl();
		red_tbl_t tbl;
		for (int i = 0; i < (1 << FIELD_W); i++) begin
			tbl[i] = RES_W'(i % MODULUS);
		end
		return tbl;
	endfunction

	localparam red_tbl_t RED_TBL = build_red_tbl();

	// Channel words
	typedef struct packed {
		logic [FIELD_W-1:0] entry_a;
		logic [FIELD_W-1:0] entry_b;
		logic [FIELD_W-1:0] entry_c;
		logic [FIELD_W-1:0] entry_d;
	} mat_t;

	typedef struct packed {
		logic [FIELD_W-1:0] inv_a;
		logic [FIELD_W-1:0] inv_b;
		logic [FIELD_W-1:0] inv_c;
		logic [FIELD_W-1:0] inv_d;
		logic [FIELD_W-1:0] det_mod;
		logic [FIELD_W-1:0] det_recip;
		logic               singular;
	} res_t;

	// Divider request and response
	typedef struct packed {
		logic          start;
		logic [DW-1:0] hi;
		logic [DW-1:0] lo;
		logic [DW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [DW-1:0] quo;
		logic [DW-1:0] rem;
	} div_rsp_t;

endpackage

// ===== src/mi26_mat_if.sv =====
// ----------------------------------------------------------------------------
// mi26_mat_if
// Valid/ready channel carrying one 2x2 matrix word.
// ----------------------------------------------------------------------------
interface mi26_mat_if
	import mi26_pkg::*;
();
	logic valid;
	logic ready;
	mat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/mi26_res_if.sv =====
// ----------------------------------------------------------------------------
// mi26_res_if
// Valid/ready channel carrying one inverse result word.
// ----------------------------------------------------------------------------
interface mi26_res_if
	import mi26_pkg::*;
();
	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/mi26_div.sv =====
// ----------------------------------------------------------------------------
// mi26_div
// Restoring divider, one quotient bit per cycle. The high half of the
// dividend must be below the divisor, so the quotient fits DW bits.
// ----------------------------------------------------------------------------
module mi26_div
	import mi26_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] sh_q;
	logic [DW-1:0] dvs_q;

	logic [DW:0] trial;
	logic        ge;

	assign trial = {rem_q, sh_q[DW-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload: load on start, shift one bit per step
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= req.hi;
			sh_q  <= req.lo;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(trial - {1'b0, dvs_q}) : DW'(trial);
			sh_q  <= {sh_q[DW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = sh_q;
	assign rsp.rem  = rem_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("done without a finished pass");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < dvs_q)
		else $error("remainder not below divisor");

endmodule

// ===== src/matrix_inverse_mod_26.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_mod_26
// Inverse of a 2x2 matrix modulo 26, as used to invert a Hill cipher key.
// ----------------------------------------------------------------------------
// Takes one matrix word [a b; c d] on mat (entries above 25 are reduced
// first) and returns one result word on res: the inverse entries, the
// determinant modulo 26, its reciprocal and a singular flag. When the
// determinant shares a factor with 26 the flag is set and the reciprocal
// and the inverse entries are zero. Every product reduction and Euclid
// division runs through one shared restoring divider that makes one quotient
// bit per cycle. An item takes 2 passes for the determinant, one pass per
// Euclid division (at most five for modulus 26) and 4 passes for the inverse
// entries; a singular matrix skips the inverse entries.
// mat is ready only while the sequencer is idle; a finished word waits in
// the output register, so the next matrix is taken while res is stalled.
// ----------------------------------------------------------------------------
module matrix_inverse_mod_26
	import mi26_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	mi26_mat_if.sink mat,
	mi26_res_if.source res
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AD_GO,
		ST_AD_WT,
		ST_BC_GO,
		ST_BC_WT,
		ST_EUC_GO,
		ST_EUC_WT,
		ST_FIN,
		ST_MUL_GO,
		ST_MUL_WT,
		ST_OUT
	} state_t;

	localparam int MW = DW + TW + 1;

	state_t state_q;

	// reduced matrix entries
	logic [RES_W-1:0] a_q, b_q, c_q, d_q;
	logic [RES_W-1:0] ad_q;
	logic [RES_W-1:0] det_q;
	logic [RES_W-1:0] recip_q;
	logic             sing_q;
	// Euclid remainders and Bezout coefficients
	logic [DW-1:0]        r0_q, r1_q;
	logic signed [TW-1:0] t0_q, t1_q;
	// inverse entries and product index
	logic [1:0]       idx_q;
	logic [RES_W-1:0] ia_q, ib_q, ic_q, id_q;
	// output register
	res_t out_q;
	logic out_valid_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	mi26_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Negated entries for the adjugate; zero stays zero
	logic [RES_W-1:0] neg_b, neg_c;
	assign neg_b = (b_q == '0) ? '0 : RES_W'(DW'(MODULUS) - DW'(b_q));
	assign neg_c = (c_q == '0) ? '0 : RES_W'(DW'(MODULUS) - DW'(c_q));

	// Multiplier operands, one product per pass
	logic [RES_W-1:0] mul_x, mul_y;
	logic [PW-1:0]    prod;

	always_comb begin
		mul_x = a_q;
		mul_y = d_q;
		case (state_q)
			ST_BC_GO: begin
				mul_x = b_q;
				mul_y = c_q;
			end
			ST_MUL_GO: begin
				mul_y = recip_q;
				case (idx_q)
					2'd0: mul_x = d_q;
					2'd1: mul_x = neg_b;
					2'd2: mul_x = neg_c;
					default: mul_x = a_q;
				endcase
			end
			default: begin
				mul_x = a_q;
				mul_y = d_q;
			end
		endcase
	end

	assign prod = PW'(mul_x) * PW'(mul_y);

	// Divider request: products reduce by the modulus, Euclid divides r0 by r1
	always_comb begin
		div_req.start   = 1'b0;
		div_req.hi      = prod[PW-1:DW];
		div_req.lo      = prod[DW-1:0];
		div_req.divisor = DW'(MODULUS);
		case (state_q)
			ST_AD_GO, ST_BC_GO, ST_MUL_GO: begin
				div_req.start = 1'b1;
			end
			ST_EUC_GO: begin
				div_req.start   = (r1_q != '0);
				div_req.hi      = '0;
				div_req.lo      = r0_q;
				div_req.divisor = r1_q;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// Determinant from ad and the bc residue just out of the divider
	logic [DW:0]      det_sum;
	logic [RES_W-1:0] det_new;
	assign det_sum = (DW + 1)'(ad_q) + (DW + 1)'(MODULUS) - (DW + 1)'(div_rsp.rem);
	assign det_new = (det_sum >= (DW + 1)'(MODULUS)) ?
		RES_W'(det_sum - (DW + 1)'(MODULUS)) : RES_W'(det_sum);

	// Coefficient update t1' = t0 - q * t1
	logic signed [MW-1:0] q_s, t1_s, qt, nt;
	assign q_s  = MW'(div_rsp.quo);
	assign t1_s = MW'(t1_q);
	assign qt   = q_s * t1_s;
	assign nt   = MW'(t0_q) - qt;

	// Normalize the final coefficient to 0..MODULUS-1
	logic signed [TW-1:0] t_pos, t_norm;
	logic                 coprime;
	assign t_pos   = (t0_q < 0) ? t0_q + MOD_T : t0_q;
	assign t_norm  = (t_pos >= MOD_T) ? t_pos - MOD_T : t_pos;
	assign coprime = (r0_q == DW'(1));

	assign mat.ready = (state_q == ST_IDLE);
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			// load a finished word, or drop the word once taken
			if (state_q == ST_OUT && (!out_valid_q || res.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (mat.valid) begin
						a_q     <= RED_TBL[mat.data.entry_a];
						b_q     <= RED_TBL[mat.data.entry_b];
						c_q     <= RED_TBL[mat.data.entry_c];
						d_q     <= RED_TBL[mat.data.entry_d];
						state_q <= ST_AD_GO;
					end
				end
				ST_AD_GO: state_q <= ST_AD_WT;
				ST_AD_WT: begin
					if (div_rsp.done) begin
						ad_q    <= RES_W'(div_rsp.rem);
						state_q <= ST_BC_GO;
					end
				end
				ST_BC_GO: state_q <= ST_BC_WT;
				ST_BC_WT: begin
					// seed Euclid with (MODULUS, det)
					if (div_rsp.done) begin
						det_q   <= det_new;
						r0_q    <= DW'(MODULUS);
						r1_q    <= DW'(det_new);
						t0_q    <= '0;
						t1_q    <= TW'(1);
						state_q <= ST_EUC_GO;
					end
				end
				ST_EUC_GO: begin
					state_q <= (r1_q == '0) ? ST_FIN : ST_EUC_WT;
				end
				ST_EUC_WT: begin
					if (div_rsp.done) begin
						r0_q    <= r1_q;
						r1_q    <= div_rsp.rem;
						t0_q    <= t1_q;
						t1_q    <= TW'(nt);
						state_q <= ST_EUC_GO;
					end
				end
				ST_FIN: begin
					sing_q  <= !coprime;
					recip_q <= coprime ? RES_W'(t_norm) : '0;
					idx_q   <= '0;
					if (coprime) begin
						state_q <= ST_MUL_GO;
					end else begin
						ia_q    <= '0;
						ib_q    <= '0;
						ic_q    <= '0;
						id_q    <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_MUL_GO: state_q <= ST_MUL_WT;
				ST_MUL_WT: begin
					if (div_rsp.done) begin
						case (idx_q)
							2'd0: ia_q <= RES_W'(div_rsp.rem);
							2'd1: ib_q <= RES_W'(div_rsp.rem);
							2'd2: ic_q <= RES_W'(div_rsp.rem);
							default: id_q <= RES_W'(div_rsp.rem);
						endcase
						idx_q   <= idx_q + 2'd1;
						state_q <= (idx_q == 2'd3) ? ST_OUT : ST_MUL_GO;
					end
				end
				ST_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || res.ready) begin
						out_q.inv_a     <= FIELD_W'(ia_q);
						out_q.inv_b     <= FIELD_W'(ib_q);
						out_q.inv_c     <= FIELD_W'(ic_q);
						out_q.inv_d     <= FIELD_W'(id_q);
						out_q.det_mod   <= FIELD_W'(det_q);
						out_q.det_recip <= FIELD_W'(recip_q);
						out_q.singular  <= sing_q;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid && mat.ready |=> state_q == ST_AD_GO)
		else $error("accepted word did not start a pass");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_AD_WT || state_q == ST_BC_WT ||
			state_q == ST_EUC_WT || state_q == ST_MUL_WT)
		else $error("divider result with no pass waiting");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.singular |-> out_q.det_recip == '0 &&
			out_q.inv_a == '0 && out_q.inv_b == '0 &&
			out_q.inv_c == '0 && out_q.inv_d == '0)
		else $error("singular word carries a nonzero inverse");

endmodule

// ===== sim/matrix_inverse_mod_26_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_inverse_mod_26_tb
// Self-checking bench for the 2x2 key inverse modulo 26.
// ----------------------------------------------------------------------------
// A directed table covers the corner matrices first: zero and identity keys,
// entries above 25, singular determinants (0, 2, 13) and exact multiples of
// 26. About 400 random matrices follow. Every accepted matrix word gets an
// expected result word, either typed into the table or computed by a local
// inverse calculation, and every result word leaving the block is compared
// field by field with the oldest expectation. Both sides idle at random; the
// result side also holds off for a long stretch so the block backs up, and
// the matrix side once waits for the block to drain completely.
// ----------------------------------------------------------------------------
module matrix_inverse_mod_26_tb;
	import mi26_pkg::*;

	// One row of the directed table: the matrix, and its expected result
	// when that result is obvious by inspection (has_key_inverse set).
	typedef struct packed {
		mat_t key;
		logic has_key_inverse;
		res_t key_inverse;
	} key_row_t;

	localparam int N_CORNER = 20;
	localparam int N_RANDOM = 400;
	// long receiver hold-off, in clock cycles; several item times
	localparam int HOLD_CYCLES = 600;
	// drain margin at the end, above the worst item time
	localparam int DRAIN_CYCLES = 150;

	localparam key_row_t CORNER_KEYS [N_CORNER] = '{
		// zero key: determinant 0, so singular and all zero
		'{'{5'd0, 5'd0, 5'd0, 5'd0}, 1'b1, '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 1'b1}},
		// identity is its own inverse
		'{'{5'd1, 5'd0, 5'd0, 5'd1}, 1'b1, '{5'd1, 5'd0, 5'd0, 5'd1, 5'd1, 5'd1, 1'b0}},
		// minus identity: 25*25 = 625 = 1 mod 26, self inverse
		'{'{5'd25, 5'd0, 5'd0, 5'd25}, 1'b1,
			'{5'd25, 5'd0, 5'd0, 5'd25, 5'd1, 5'd1, 1'b0}},
		// all 25: ad - bc cancels
		'{'{5'd25, 5'd25, 5'd25, 5'd25}, 1'b1,
			'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 1'b1}},
		// all bits set: every entry reduces to 5, determinant 0
		'{'{5'd31, 5'd31, 5'd31, 5'd31}, 1'b1,
			'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 1'b1}},
		// 27 reduces to 1: identity again
		'{'{5'd27, 5'd0, 5'd0, 5'd27}, 1'b1, '{5'd1, 5'd0, 5'd0, 5'd1, 5'd1, 5'd1, 1'b0}},
		// all 26 reduce to 0
		'{'{5'd26, 5'd26, 5'd26, 5'd26}, 1'b1,
			'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 1'b1}},
		// textbook key [3 3; 2 5]: det 9, 1/9 = 3, inverse [15 17; 20 9]
		'{'{5'd3, 5'd3, 5'd2, 5'd5}, 1'b1,
			'{5'd15, 5'd17, 5'd20, 5'd9, 5'd9, 5'd3, 1'b0}},
		// determinant shares the factor 13
		'{'{5'd13, 5'd0, 5'd0, 5'd1}, 1'b1,
			'{5'd0, 5'd0, 5'd0, 5'd0, 5'd13, 5'd0, 1'b1}},
		// determinant shares the factor 2
		'{'{5'd2, 5'd0, 5'd0, 5'd1}, 1'b1, '{5'd0, 5'd0, 5'd0, 5'd0, 5'd2, 5'd0, 1'b1}},
		// the rest go through the predictor
		'{'{5'd0, 5'd1, 5'd1, 5'd0}, 1'b0, '0},
		'{'{5'd0, 5'd25, 5'd25, 5'd0}, 1'b0, '0},
		'{'{5'd31, 5'd0, 5'd0, 5'd30}, 1'b0, '0},
		'{'{5'd29, 5'd28, 5'd0, 5'd31}, 1'b0, '0},
		'{'{5'd5, 5'd8, 5'd17, 5'd3}, 1'b0, '0},
		'{'{5'd1, 5'd1, 5'd1, 5'd2}, 1'b0, '0},
		'{'{5'd0, 5'd13, 5'd2, 5'd0}, 1'b0, '0},
		'{'{5'd7, 5'd2, 5'd1, 5'd3}, 1'b0, '0},
		'{'{5'd25, 5'd24, 5'd23, 5'd22}, 1'b0, '0},
		'{'{5'd16, 5'd31, 5'd16, 5'd31}, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	mi26_mat_if mat_ch ();
	mi26_res_if res_ch ();

	matrix_inverse_mod_26 dut (
		.clk    (clk),
		.arst_n (arst_n),
		.mat    (mat_ch),
		.res    (res_ch)
	);

	// expected result words, oldest first
	res_t pending_inverses [$];
	// typed expectation travelling with the word on mat
	logic word_has_inverse;
	res_t word_inverse;
	// no random idling on either side while set
	logic steady;
	int   mismatches;
	int   words_checked;

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out the inverse of a key modulo 26 the long way: reduce, take the
	// determinant, run extended Euclid on (26, det), scale the adjugate.
	function automatic res_t invert_key(mat_t key);
		int   a, b, c, d;
		int   det, recip;
		int   r_prev, r_cur, s_prev, s_cur, quo, r_next, s_next;
		res_t inv;
		a = int'(key.entry_a) % MODULUS;
		b = int'(key.entry_b) % MODULUS;
		c = int'(key.entry_c) % MODULUS;
		d = int'(key.entry_d) % MODULUS;
		det = ((a * d) % MODULUS + MODULUS - (b * c) % MODULUS) % MODULUS;
		r_prev = MODULUS;
		r_cur  = det;
		s_prev = 0;
		s_cur  = 1;
		while (r_cur != 0) begin
			quo    = r_prev / r_cur;
			r_next = r_prev - quo * r_cur;
			s_next = s_prev - quo * s_cur;
			r_prev = r_cur;
			r_cur  = r_next;
			s_prev = s_cur;
			s_cur  = s_next;
		end
		inv = '0;
		inv.det_mod  = FIELD_W'(det);
		// gcd other than 1 means no reciprocal; leave the rest at zero
		inv.singular = (r_prev != 1);
		if (!inv.singular) begin
			recip = ((s_prev % MODULUS) + MODULUS) % MODULUS;
			inv.det_recip = FIELD_W'(recip);
			inv.inv_a = FIELD_W'((d * recip) % MODULUS);
			inv.inv_b = FIELD_W'((((MODULUS - b) % MODULUS) * recip) % MODULUS);
			inv.inv_c = FIELD_W'((((MODULUS - c) % MODULUS) * recip) % MODULUS);
			inv.inv_d = FIELD_W'((a * recip) % MODULUS);
		end
		return inv;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Mostly in-range entries; now and then 26..31 so the upper bits and
	// the reduction path get exercised.
	function automatic logic [FIELD_W-1:0] random_entry();
		if ($urandom_range(99) < 12)
			return FIELD_W'($urandom_range(31, 26));
		return FIELD_W'($urandom_range(25, 0));
	endfunction

	// Offer one matrix word. Idle gaps come only before valid rises; once up,
	// valid holds until the word is taken. Returns right after the taking edge.
	task automatic offer_key(input mat_t key, input logic has_inv, input res_t inv);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 28) begin
			mat_ch.valid <= 1'b0;
			@(negedge clk);
		end
		mat_ch.valid     <= 1'b1;
		mat_ch.data      <= key;
		word_has_inverse <= has_inv;
		word_inverse     <= inv;
		do
			@(posedge clk);
		while (!mat_ch.ready);
	endtask

	// Record an expectation per accepted matrix word and check each result
	// word against the oldest one. Both sides are sampled at the rising edge.
	always @(posedge clk) begin : scoreboard
		res_t want;
		if (arst_n) begin
			if (mat_ch.valid && mat_ch.ready)
				pending_inverses.push_back(word_has_inverse ? word_inverse
					: invert_key(mat_ch.data));
			if (res_ch.valid && res_ch.ready) begin
				if (pending_inverses.size() == 0) begin
					$error("result word with no matrix outstanding");
					mismatches++;
				end else begin
					want = pending_inverses.pop_front();
					check_field("inv_a", want.inv_a, res_ch.data.inv_a);
					check_field("inv_b", want.inv_b, res_ch.data.inv_b);
					check_field("inv_c", want.inv_c, res_ch.data.inv_c);
					check_field("inv_d", want.inv_d, res_ch.data.inv_d);
					check_field("det_mod", want.det_mod, res_ch.data.det_mod);
					check_field("det_recip", want.det_recip, res_ch.data.det_recip);
					check_field("singular", want.singular, res_ch.data.singular);
					words_checked++;
				end
			end
		end
	end

	// Result side: random stalls, plus one long hold-off once the run is well
	// under way so the output register fills and mat stops taking words.
	initial begin : result_side
		bit held;
		held = 1'b0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && words_checked >= 120) begin
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				res_ch.ready <= steady || ($urandom_range(99) >= 28);
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin : matrix_side
		mat_t key;
		mat_ch.valid     = 1'b0;
		mat_ch.data      = '0;
		word_has_inverse = 1'b0;
		word_inverse     = '0;
		steady           = 1'b0;
		mismatches       = 0;
		words_checked    = 0;

		// assert reset, then release it on a falling edge
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// walk the corner table
		foreach (CORNER_KEYS[i])
			offer_key(CORNER_KEYS[i].key, CORNER_KEYS[i].has_key_inverse,
				CORNER_KEYS[i].key_inverse);

		for (int n = 0; n < N_RANDOM; n++) begin
			// a stretch with no idling on either side
			if (n == 180)
				steady <= 1'b1;
			if (n == 260)
				steady <= 1'b0;
			// let the block drain fully before going on
			if (n == 300) begin
				@(negedge clk);
				mat_ch.valid <= 1'b0;
				wait (pending_inverses.size() == 0);
			end
			key.entry_a = random_entry();
			key.entry_b = random_entry();
			key.entry_c = random_entry();
			key.entry_d = random_entry();
			offer_key(key, 1'b0, '0);
		end

		// drop valid, wait for the last results, then a margin for strays
		@(negedge clk);
		mat_ch.valid <= 1'b0;
		wait (pending_inverses.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/mi26_pkg.sv
src/mi26_mat_if.sv
src/mi26_res_if.sv
src/mi26_div.sv
src/matrix_inverse_mod_26.sv
sim/matrix_inverse_mod_26_tb.sv
